// ===== design/mf5_pkg.sv =====
// ----------------------------------------------------------------------------
// mf5_pkg
// Shared types and constants for the 5x5 median filter.
// ----------------------------------------------------------------------------
package mf5_pkg;

   localparam int PIX_W     = 8;
   localparam int CH_N      = 3;
   localparam int RGB_W     = PIX_W * CH_N;
   localparam int WIN_DIM   = 5;
   localparam int WIN_N     = WIN_DIM * WIN_DIM;
   localparam int LINE_ROWS = WIN_DIM - 1;
   localparam int LINE_W    = RGB_W * LINE_ROWS;
   localparam int MED_RANK  = WIN_N / 2;
   localparam int ROW_W     = 12;
   localparam int HEIGHT_MAX = 4096;
   localparam int CSR_W     = 13;
   localparam int IMG_W_W   = 11;

   typedef logic [PIX_W-1:0] pix_type;
   typedef logic [RGB_W-1:0] rgb_type;

   localparam logic CSR_IDX_WIDTH  = 1'b0;
   localparam logic CSR_IDX_HEIGHT = 1'b1;

endpackage

// ===== design/mf5_line_store.sv =====
// ----------------------------------------------------------------------------
// mf5_line_store
// Four-row line store, one 96-bit word per column, with write-to-read bypass.
// ----------------------------------------------------------------------------
module mf5_line_store import mf5_pkg::*; #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [LINE_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [LINE_W-1:0] wr_data
);

   logic [LINE_W-1:0] mem [DEPTH];
   logic [LINE_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_ff <= wr_data;
         end else begin
            rd_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_ff;

endmodule

// ===== design/mf5_median.sv =====
// ----------------------------------------------------------------------------
// mf5_median
// Median of 25 values: registered comparison matrix, then rank select.
// ----------------------------------------------------------------------------
module mf5_median import mf5_pkg::*; (
   input  logic    clock,
   input  logic    en,
   input  pix_type vals [WIN_N],
   output pix_type med
);

   logic [WIN_N-1:0] lt_ff [WIN_N];
   pix_type          val_ff [WIN_N];
   pix_type          med_in;
   pix_type          med_ff;

   // lt_ff[i][j]: value j is below value i
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < WIN_N; i++) begin
            val_ff[i] <= vals[i];
            for (int j = 0; j < WIN_N; j++) begin
               lt_ff[i][j] <= (vals[j] < vals[i]);
            end
         end
      end
   end

   always_comb begin
      logic [WIN_N-1:0] gt_v;
      med_in = '0;
      gt_v   = '0;
      for (int i = 0; i < WIN_N; i++) begin
         for (int j = 0; j < WIN_N; j++) begin
            gt_v[j] = lt_ff[j][i];
         end
         if (($countones(lt_ff[i]) <= MED_RANK) && ($countones(gt_v) <= MED_RANK)) begin
            med_in = med_in | val_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         med_ff <= med_in;
      end
   end

   assign med = med_ff;

endmodule

// ===== design/median_filter_5x5.sv =====
// A pixel passes stage A, window stage B, median stage C and the result register.
// Throughput: one pixel per cycle; the whole pipeline holds only while a result
// waits under rsp_stall.
// Reset clears position counters and valid flags and restores width 640 and
// height 480; line store contents are not cleared.
// ----------------------------------------------------------------------------
// median_filter_5x5
// 5x5 per-channel median filter over a raster pixel stream.
// ----------------------------------------------------------------------------
module median_filter_5x5 import mf5_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [PIX_W-1:0]             req_blue_in,
   input  logic [PIX_W-1:0]             req_green_in,
   input  logic [PIX_W-1:0]             req_red_in,
   input  logic                         req_frame_start,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [PIX_W-1:0]             rsp_blue_out,
   output logic [PIX_W-1:0]             rsp_green_out,
   output logic [PIX_W-1:0]             rsp_red_out,
   output logic [ROW_W-1:0]             rsp_center_row,
   output logic [$clog2(MAX_WIDTH)-1:0] rsp_center_col,
   output logic                         rsp_frame_done,
   input  logic                         csr_we,
   input  logic                         csr_idx,
   input  logic [CSR_W-1:0]             csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WLAST_RST = ((640 > MAX_WIDTH) ? MAX_WIDTH : 640) - 1;

   logic          en;
   logic          accept;

   logic [CW-1:0]    wlast_ff;
   logic [ROW_W-1:0] hlast_ff;
   logic [13:0]      w_ext;
   logic [13:0]      w_clamp;
   logic [13:0]      h_ext;
   logic [13:0]      h_clamp;

   logic [CW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [CW-1:0]    x;
   logic [ROW_W-1:0] y;

   logic             a_valid_ff;
   logic             a_emit_ff;
   logic             a_done_ff;
   rgb_type          a_pix_ff;
   logic [CW-1:0]    a_col_ff;
   logic [ROW_W-1:0] a_row_ff;

   logic [LINE_W-1:0] rd_data;
   logic [LINE_W-1:0] wr_data;
   rgb_type           col_v [WIN_DIM];

   rgb_type          win_ff [WIN_DIM][WIN_DIM];
   logic             b_valid_ff;
   logic             b_done_ff;
   logic [CW-1:0]    b_col_ff;
   logic [ROW_W-1:0] b_row_ff;

   logic             c_valid_ff;
   logic             c_done_ff;
   logic [CW-1:0]    c_col_ff;
   logic [ROW_W-1:0] c_row_ff;

   logic             rsp_valid_ff;
   logic             rsp_done_ff;
   logic [CW-1:0]    rsp_col_ff;
   logic [ROW_W-1:0] rsp_row_ff;

   pix_type          ch_vals [CH_N][WIN_N];
   pix_type          ch_med  [CH_N];

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;
   assign accept    = req_valid && en;

   // register writes, clamped on the way in
   always_comb begin
      w_ext   = 14'(csr_wdata[IMG_W_W-1:0]);
      h_ext   = 14'(csr_wdata);
      w_clamp = w_ext;
      if (w_ext < 14'(WIN_DIM)) w_clamp = 14'(WIN_DIM);
      if (w_ext > 14'(MAX_WIDTH)) w_clamp = 14'(MAX_WIDTH);
      h_clamp = h_ext;
      if (h_ext < 14'(WIN_DIM)) h_clamp = 14'(WIN_DIM);
      if (h_ext > 14'(HEIGHT_MAX)) h_clamp = 14'(HEIGHT_MAX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wlast_ff <= CW'(WLAST_RST);
         hlast_ff <= ROW_W'(479);
      end else if (csr_we) begin
         if (csr_idx == CSR_IDX_WIDTH) begin
            wlast_ff <= CW'(w_clamp - 14'd1);
         end else begin
            hlast_ff <= ROW_W'(h_clamp - 14'd1);
         end
      end
   end

   // position counters
   always_comb begin
      x = req_frame_start ? '0 : col_ff;
      y = req_frame_start ? '0 : row_ff;
      col_in = x + CW'(1);
      row_in = y;
      if (x >= wlast_ff) begin
         col_in = '0;
         row_in = (y >= hlast_ff) ? '0 : y + ROW_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // stage A: pixel registered, line store read in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_pix_ff  <= {req_red_in, req_green_in, req_blue_in};
         a_col_ff  <= x;
         a_row_ff  <= y;
         a_emit_ff <= (x >= CW'(LINE_ROWS)) && (y >= ROW_W'(LINE_ROWS));
         a_done_ff <= (x >= wlast_ff) && (y >= hlast_ff);
      end
   end

   assign wr_data = {a_pix_ff, rd_data[LINE_W-1:RGB_W]};

   mf5_line_store #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (en),
      .rd_addr (x),
      .rd_data (rd_data),
      .wr_en   (en && a_valid_ff),
      .wr_addr (a_col_ff),
      .wr_data (wr_data)
   );

   always_comb begin
      for (int r = 0; r < LINE_ROWS; r++) begin
         col_v[r] = rd_data[r*RGB_W +: RGB_W];
      end
      col_v[LINE_ROWS] = a_pix_ff;
   end

   // stage B: window shift
   always_ff @(posedge clock) begin
      if (en && a_valid_ff) begin
         for (int r = 0; r < WIN_DIM; r++) begin
            for (int c = 0; c < WIN_DIM - 1; c++) begin
               win_ff[r][c] <= win_ff[r][c+1];
            end
            win_ff[r][WIN_DIM-1] <= col_v[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff   <= a_valid_ff && a_emit_ff;
         c_valid_ff   <= b_valid_ff;
         rsp_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_done_ff   <= a_done_ff;
         b_col_ff    <= a_col_ff - CW'(2);
         b_row_ff    <= a_row_ff - ROW_W'(2);
         c_done_ff   <= b_done_ff;
         c_col_ff    <= b_col_ff;
         c_row_ff    <= b_row_ff;
         rsp_done_ff <= c_done_ff;
         rsp_col_ff  <= c_col_ff;
         rsp_row_ff  <= c_row_ff;
      end
   end

   // stages C and result: per-channel median
   always_comb begin
      for (int k = 0; k < CH_N; k++) begin
         for (int r = 0; r < WIN_DIM; r++) begin
            for (int c = 0; c < WIN_DIM; c++) begin
               ch_vals[k][r*WIN_DIM+c] = win_ff[r][c][k*PIX_W +: PIX_W];
            end
         end
      end
   end

   for (genvar k = 0; k < CH_N; k++) begin : g_ch
      mf5_median u_median (
         .clock (clock),
         .en    (en),
         .vals  (ch_vals[k]),
         .med   (ch_med[k])
      );
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_blue_out   = ch_med[0];
   assign rsp_green_out  = ch_med[1];
   assign rsp_red_out    = ch_med[2];
   assign rsp_center_row = rsp_row_ff;
   assign rsp_center_col = rsp_col_ff;
   assign rsp_frame_done = rsp_done_ff;

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      accept |=> a_valid_ff)
      else $error("accepted pixel missing from stage A");

   a_frame_start_origin: assert property (@(posedge clock) disable iff (reset)
      accept && req_frame_start |=> (a_col_ff == '0) && (a_row_ff == '0))
      else $error("frame start did not reset position");

   a_emit_forward: assert property (@(posedge clock) disable iff (reset)
      en && a_valid_ff |=> b_valid_ff == $past(a_emit_ff))
      else $error("emit flag lost between stages");

   a_result_forward: assert property (@(posedge clock) disable iff (reset)
      en && c_valid_ff |=> rsp_valid_ff)
      else $error("median result dropped");

endmodule
